### rtl/wsp_pkg.sv
// ---------------------------------------------------------------------------
// wsp_pkg: shared types and constants of the wheel speed loop
// Field widths, register indexes, per-wheel state word and stage records.
// ---------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

  // Number of wheels kept in the state memory (the wheel field has two bits)
  localparam int WHEELS   = 4;
  localparam int WHEEL_W  = 2;

  // Filter coefficient, about 0.30 in Q0.16
  localparam logic [15:0] ALPHA_Q16 = 16'd19661;

  // Shift of the rounding steps (a shift by 16)
  localparam int RND_SHIFT = 16;

  // Width of the summed duty term in Q.16
  localparam int U_W = 44;

  // Stream widths
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 56;
  localparam int M_TUSER_W = 1;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FF_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG_BASE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRV_INV   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_INV   = 3'd7;

  localparam logic [9:0]  DUTY_FS_RST  = 10'd400;
  localparam logic [11:0] LAG_BASE_RST = 12'd60;

  // One input item
  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic signed [15:0] raw_delta;
    logic signed [19:0] target;
    logic               stop;
    logic               brake;
  } item_t;

  // Per-wheel loop state, one memory word
  typedef struct packed {
    logic signed [23:0] lag;
    logic signed [23:0] prev;
    logic signed [23:0] speed;
  } state_t;

  // Result of the error and lag stage
  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic signed [15:0] delta;
    logic signed [19:0] target;
    logic signed [23:0] speed;
    logic signed [24:0] diff;
    logic signed [23:0] err;
    logic signed [24:0] derr;
    logic signed [23:0] lag;
    logic               active;
    logic               stop;
    logic               brake;
    logic               tzero;
  } calc_t;

  // Fields that ride along to the output
  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic signed [15:0] delta;
    logic signed [23:0] speed;
    logic               drive;
    logic               brake_o;
  } meta_t;

  // Saturate to 24 bits signed
  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [25:0] hi;
    logic signed [25:0] lo;
    hi = 26'sd8388607;
    lo = -26'sd8388608;
    if (v > hi) begin
      sat24 = 24'sh7FFFFF;
    end else if (v < lo) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[23:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/wsp_state_mem.sv
// ---------------------------------------------------------------------------
// wsp_state_mem: per-wheel loop state memory
// One write port, one read port with registered data. An entry that was
// never written since reset reads as zero through its valid bit.
// ---------------------------------------------------------------------------
`default_nettype none

module wsp_state_mem (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rd_en_i,
  input  wire logic [wsp_pkg::WHEEL_W-1:0]  rd_addr_i,
  output wsp_pkg::state_t                   rd_data_o,
  input  wire logic                         wr_en_i,
  input  wire logic [wsp_pkg::WHEEL_W-1:0]  wr_addr_i,
  input  wire wsp_pkg::state_t              wr_data_i
);

  wsp_pkg::state_t                mem_q [wsp_pkg::WHEELS];
  logic [wsp_pkg::WHEELS-1:0]     valid_q;
  wsp_pkg::state_t                rd_data_q;

  // Mark written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/wsp_loop_calc.sv
// ---------------------------------------------------------------------------
// wsp_loop_calc: encoder polarity, velocity error and lag clamp
// Combines one item with its wheel's stored state ahead of the multipliers.
// ---------------------------------------------------------------------------
`default_nettype none

module wsp_loop_calc (
  input  wire wsp_pkg::item_t   item_i,
  input  wire wsp_pkg::state_t  state_i,
  input  wire logic [11:0]      lag_base_i,
  input  wire logic             enc_inv_i,
  output wsp_pkg::calc_t        calc_o
);

  logic signed [15:0] d;
  logic signed [23:0] big_d;
  logic signed [24:0] e_raw;
  logic signed [20:0] t21;
  logic [20:0]        abs_t;
  logic [22:0]        lim;
  logic signed [25:0] lim_s;
  logic signed [25:0] lag_sum;
  logic signed [23:0] err;

  always_comb begin
    // Correct encoder polarity, saturating the one value that overflows
    if (enc_inv_i) begin
      d = (item_i.raw_delta == 16'sh8000) ? 16'sh7FFF : -item_i.raw_delta;
    end else begin
      d = item_i.raw_delta;
    end
    big_d = {d, 8'h00};

    // Velocity error against the target step
    e_raw = 25'(item_i.target) - 25'(big_d);
    err   = wsp_pkg::sat24(26'(e_raw));

    // Lag limit grows with target speed
    t21   = 21'(item_i.target);
    abs_t = t21[20] ? 21'(-t21) : 21'(t21);
    lim   = 23'({lag_base_i, 8'h00}) + {abs_t, 2'b00};
    lim_s = $signed(26'(lim));

    // Accumulate lag and clamp it to the limit
    lag_sum = 26'(state_i.lag) + 26'(e_raw);

    calc_o.wheel  = item_i.wheel;
    calc_o.delta  = d;
    calc_o.target = item_i.target;
    calc_o.speed  = state_i.speed;
    calc_o.diff   = 25'(big_d) - 25'(state_i.speed);
    calc_o.err    = err;
    calc_o.derr   = 25'(err) - 25'(state_i.prev);
    if (lag_sum > lim_s) begin
      calc_o.lag = lim_s[23:0];
    end else if (lag_sum < -lim_s) begin
      calc_o.lag = 24'(-lim_s);
    end else begin
      calc_o.lag = lag_sum[23:0];
    end
    calc_o.active = (int'(item_i.wheel) < wsp_pkg::WHEELS);
    calc_o.stop   = item_i.stop;
    calc_o.brake  = item_i.brake;
    calc_o.tzero  = (item_i.target == 20'sd0);
  end

endmodule

`default_nettype wire

### rtl/wsp_duty_calc.sv
// ---------------------------------------------------------------------------
// wsp_duty_calc: duty rounding and drive polarity
// Rounds the clamped Q.16 duty to nearest, ties away from zero.
// ---------------------------------------------------------------------------
`default_nettype none

module wsp_duty_calc (
  input  wire logic signed [26:0] uc_i,
  input  wire logic               drive_i,
  input  wire logic               invert_i,
  output logic signed [10:0]      duty_o
);

  logic [26:0]        mag_u;
  logic [26:0]        mag_r;
  logic signed [10:0] mag;
  logic signed [10:0] duty_s;

  always_comb begin
    // Round the magnitude, then restore sign
    mag_u  = uc_i[26] ? 27'(-uc_i) : 27'(uc_i);
    mag_r  = mag_u + 27'(1 << (wsp_pkg::RND_SHIFT - 1));
    mag    = $signed(mag_r[wsp_pkg::RND_SHIFT +: 11]);
    duty_s = uc_i[26] ? -mag : mag;
    // Apply wheel polarity; coast and stop items drive nothing
    if (!drive_i) begin
      duty_o = 11'sd0;
    end else if (invert_i) begin
      duty_o = -duty_s;
    end else begin
      duty_o = duty_s;
    end
  end

endmodule

`default_nettype wire

### rtl/wheel_speed_pid_with_lag_clamp.sv
// ---------------------------------------------------------------------------
// wheel_speed_pid_with_lag_clamp: per-wheel velocity loop with lag clamp
// Feed-forward plus PID on velocity error and clamped position lag.
// ---------------------------------------------------------------------------
// Each input item is one control tick for one wheel and gives exactly one
// result item. Items for different wheels are taken one per cycle unless
// the output stalls; an item is held while an earlier item for its wheel
// is in stages 1 to 3, the read-modify-write loop of the per-wheel state
// memory (read, error/lag stage, multiply, filter and write back). The
// state memory needs no clearing pass: a valid bit per wheel makes
// unwritten entries read as zero right after reset.
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_wdata_i and
// must only change while no item is in flight.
`default_nettype none

module wheel_speed_pid_with_lag_clamp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input items
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [1:0] wheel, [17:2] raw_delta, [37:18] target_step, [39:38] zero
  input  wire logic [wsp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] stop, [1] brake
  input  wire logic [wsp_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  // Result items
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] wheel_out, [12:2] duty, [36:13] speed_filtered,
  // [52:37] delta_out, [55:53] zero
  output logic [wsp_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  // [0] brake_out
  output logic [wsp_pkg::M_TUSER_W-1:0]          m_axis_tuser,
  // Configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [wsp_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  wire logic [wsp_pkg::CFG_DAT_W-1:0]     cfg_wdata_i
);

  // Configuration registers
  logic [15:0] ff_gain_q, kp_gain_q, ki_gain_q, kd_gain_q;
  logic [9:0]  duty_fs_q;
  logic [11:0] lag_base_q;
  logic [3:0]  drv_inv_q, enc_inv_q;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_gain_q  <= '0;
      kp_gain_q  <= '0;
      ki_gain_q  <= '0;
      kd_gain_q  <= '0;
      duty_fs_q  <= wsp_pkg::DUTY_FS_RST;
      lag_base_q <= wsp_pkg::LAG_BASE_RST;
      drv_inv_q  <= '0;
      enc_inv_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        wsp_pkg::CFG_FF_GAIN:  ff_gain_q  <= cfg_wdata_i;
        wsp_pkg::CFG_KP_GAIN:  kp_gain_q  <= cfg_wdata_i;
        wsp_pkg::CFG_KI_GAIN:  ki_gain_q  <= cfg_wdata_i;
        wsp_pkg::CFG_KD_GAIN:  kd_gain_q  <= cfg_wdata_i;
        wsp_pkg::CFG_DUTY_FS:  duty_fs_q  <= cfg_wdata_i[9:0];
        wsp_pkg::CFG_LAG_BASE: lag_base_q <= cfg_wdata_i[11:0];
        wsp_pkg::CFG_DRV_INV:  drv_inv_q  <= cfg_wdata_i[3:0];
        wsp_pkg::CFG_ENC_INV:  enc_inv_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Unpack the input item
  wsp_pkg::item_t in_item;
  assign in_item.wheel     = s_axis_tdata[1:0];
  assign in_item.raw_delta = s_axis_tdata[17:2];
  assign in_item.target    = s_axis_tdata[37:18];
  assign in_item.stop      = s_axis_tuser[0];
  assign in_item.brake     = s_axis_tuser[1];

  // Pipeline valid bits and stage records
  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;
  logic hazard, acc, wr_en;

  wsp_pkg::item_t             st1_q;
  wsp_pkg::state_t            rd_state;
  wsp_pkg::calc_t             calc;
  wsp_pkg::calc_t             st2_q, st3_q;
  logic signed [wsp_pkg::U_W-1:0] p_ff_q, p_kp_q, p_ki_q, p_kd_q;
  logic signed [40:0]         p_flt_q;
  logic signed [wsp_pkg::U_W-1:0] sa_q, sb_q;
  wsp_pkg::meta_t             meta4_d, meta4_q, meta5_q, meta_o_q;
  logic signed [26:0]         uc_d, uc_q;
  logic signed [10:0]         duty, duty_q;

  // Stage advance: a stage moves when the next one is empty or moving
  assign rdy_o = !ov_q || m_axis_tready;
  assign rdy5  = !v5_q || rdy_o;
  assign rdy4  = !v4_q || rdy5;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;

  // Hold a new item while its wheel is still being updated
  assign hazard = (v1_q && st1_q.wheel == in_item.wheel) ||
                  (v2_q && st2_q.wheel == in_item.wheel) ||
                  (v3_q && st3_q.wheel == in_item.wheel);
  assign s_axis_tready = rdy1 && !hazard;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q <= acc;
      if (rdy2)  v2_q <= v1_q;
      if (rdy3)  v3_q <= v2_q;
      if (rdy4)  v4_q <= v3_q;
      if (rdy5)  v5_q <= v4_q;
      if (rdy_o) ov_q <= v5_q;
    end
  end

  // State memory: read on accept, write back when leaving stage 3
  wsp_pkg::state_t wr_state;
  logic signed [40:0] flt_rnd;
  logic signed [24:0] flt_adj;
  logic signed [23:0] s_new;

  assign wr_en = v3_q && rdy4 && st3_q.active;

  wsp_state_mem u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .rd_addr_i (in_item.wheel),
    .rd_data_o (rd_state),
    .wr_en_i   (wr_en),
    .wr_addr_i (st3_q.wheel),
    .wr_data_i (wr_state)
  );

  // Stage 1: capture item
  always_ff @(posedge clk_i) begin
    if (acc) st1_q <= in_item;
  end

  // Stage 1 to 2: error and lag against stored state
  wsp_loop_calc u_loop_calc (
    .item_i     (st1_q),
    .state_i    (rd_state),
    .lag_base_i (lag_base_q),
    .enc_inv_i  (enc_inv_q[st1_q.wheel]),
    .calc_o     (calc)
  );

  always_ff @(posedge clk_i) begin
    if (rdy2) st2_q <= calc;
  end

  // Stage 2 to 3: gain and filter products
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      p_ff_q  <= 44'(st2_q.target) * 44'($signed({1'b0, ff_gain_q}));
      p_kp_q  <= 44'(st2_q.err)    * 44'($signed({1'b0, kp_gain_q}));
      p_ki_q  <= 44'(st2_q.lag)    * 44'($signed({1'b0, ki_gain_q}));
      p_kd_q  <= 44'(st2_q.derr)   * 44'($signed({1'b0, kd_gain_q}));
      p_flt_q <= 41'(st2_q.diff)   * 41'($signed({1'b0, wsp_pkg::ALPHA_Q16}));
      st3_q   <= st2_q;
    end
  end

  // Stage 3: finish filter, write back state, pair up duty terms
  always_comb begin
    flt_rnd = p_flt_q + 41'sd32768;
    flt_adj = flt_rnd[40:wsp_pkg::RND_SHIFT];
    s_new   = wsp_pkg::sat24(26'(st3_q.speed) + 26'(flt_adj));

    if (st3_q.stop) begin
      wr_state = '0;
    end else begin
      wr_state.speed = s_new;
      wr_state.lag   = st3_q.tzero ? 24'sd0 : st3_q.lag;
      wr_state.prev  = st3_q.tzero ? 24'sd0 : st3_q.err;
    end

    meta4_d.wheel   = st3_q.wheel;
    meta4_d.delta   = st3_q.delta;
    meta4_d.speed   = (st3_q.active && !st3_q.stop) ? s_new : 24'sd0;
    meta4_d.drive   = st3_q.active && !st3_q.stop && !st3_q.tzero;
    meta4_d.brake_o = st3_q.active && st3_q.stop && st3_q.brake;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      sa_q    <= p_ff_q + p_kp_q;
      sb_q    <= p_ki_q + p_kd_q;
      meta4_q <= meta4_d;
    end
  end

  // Stage 4: total duty term, saturate at full scale
  logic signed [wsp_pkg::U_W-1:0] u_sum;
  logic signed [wsp_pkg::U_W-1:0] fs;

  always_comb begin
    u_sum = sa_q + sb_q;
    fs    = $signed(wsp_pkg::U_W'({duty_fs_q, 16'h0000}));
    if (u_sum > fs) begin
      uc_d = 27'(fs);
    end else if (u_sum < -fs) begin
      uc_d = 27'(-fs);
    end else begin
      uc_d = 27'(u_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      uc_q    <= uc_d;
      meta5_q <= meta4_q;
    end
  end

  // Stage 5: round and apply polarity into the output register
  wsp_duty_calc u_duty_calc (
    .uc_i     (uc_q),
    .drive_i  (meta5_q.drive),
    .invert_i (drv_inv_q[meta5_q.wheel]),
    .duty_o   (duty)
  );

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      duty_q   <= duty;
      meta_o_q <= meta5_q;
    end
  end

  // Pack the result item
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'b000, meta_o_q.delta, meta_o_q.speed, duty_q, meta_o_q.wheel};
  assign m_axis_tuser  = meta_o_q.brake_o;

  // No two items for the same wheel may be inside the update loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q) |-> (st1_q.wheel != st2_q.wheel))
    else $error("same wheel in stages 1 and 2");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && (v1_q || v2_q)) |->
      ((!v1_q || st1_q.wheel != st3_q.wheel) && (!v2_q || st2_q.wheel != st3_q.wheel)))
    else $error("same wheel in stage 3 and an earlier stage");
  // A braking stop result carries no duty and no speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (duty_q == 11'sd0 && meta_o_q.speed == 24'sd0))
    else $error("brake result with nonzero duty or speed");
  // An accepted item always lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> v1_q)
    else $error("accepted item lost");

endmodule

`default_nettype wire

### dv/wheel_speed_pid_with_lag_clamp_tb.sv
// ---------------------------------------------------------------------------
// wheel_speed_pid_with_lag_clamp_tb: self-checking bench of the wheel loop
// Drives control ticks on the input stream and computes the duty, filtered
// speed and corrected delta of every tick with a cycle-free model of the
// loop. Each result on the output stream is compared field by field with the
// oldest expected one. Register settings change between phases only.
// ---------------------------------------------------------------------------
`default_nettype none

module wheel_speed_pid_with_lag_clamp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RANDOM_ITEMS = 850;
  localparam int     PHASES       = 8;
  localparam int     DRAIN_CYCLES = 32;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam longint FILTER_ALPHA = 19661;

  // Register image of the loop
  typedef struct {
    logic [15:0] ff;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [9:0]  dfs;
    logic [11:0] lag_base;
    logic [3:0]  drv_inv;
    logic [3:0]  enc_inv;
  } loop_cfg_t;

  // One result item as seen on the output stream
  typedef struct packed {
    logic [1:0]         wheel;
    logic signed [10:0] duty;
    logic               brake;
    logic signed [23:0] speed;
    logic signed [15:0] delta;
  } drive_res_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [wsp_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic [wsp_pkg::S_TUSER_W-1:0] s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [wsp_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [wsp_pkg::M_TUSER_W-1:0] m_axis_tuser;
  logic                          cfg_we_i;
  logic [wsp_pkg::CFG_IDX_W-1:0] cfg_addr_i;
  logic [wsp_pkg::CFG_DAT_W-1:0] cfg_wdata_i;

  // Model state per wheel and current register image
  logic signed [23:0] lag_mem  [wsp_pkg::WHEELS];
  logic signed [23:0] perr_mem [wsp_pkg::WHEELS];
  logic signed [23:0] spd_mem  [wsp_pkg::WHEELS];
  loop_cfg_t          loop_cfg;

  drive_res_t expected_duties[$];
  drive_res_t got_res;
  drive_res_t want_res;

  int  mismatches   = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  phases_run   = 0;
  int  cycles       = 0;
  int  sink_stall   = 0;
  int  sink_draw;
  bit  src_idle_on  = 1'b1;
  bit  sink_idle_on = 1'b1;

  wheel_speed_pid_with_lag_clamp DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Clip to 24 bits signed
  function automatic longint clip24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Compute the result of one tick and advance the wheel state
  function automatic drive_res_t predict_drive(input wsp_pkg::item_t it);
    drive_res_t r;
    longint     d, bd, tgt, s, lag, lim, e, u, fs, mag, abs_t;
    longint     ff, kp, ki, kd;
    int         w;
    w   = it.wheel;
    d   = $signed(it.raw_delta);
    tgt = $signed(it.target);
    ff  = longint'(loop_cfg.ff);
    kp  = longint'(loop_cfg.kp);
    ki  = longint'(loop_cfg.ki);
    kd  = longint'(loop_cfg.kd);
    if (loop_cfg.enc_inv[w]) begin
      d = -d;
      if (d > 32767) d = 32767;
    end
    bd = d * 256;
    r.wheel = it.wheel;
    r.duty  = '0;
    r.brake = 1'b0;
    r.speed = '0;
    r.delta = d[15:0];
    if (it.stop) begin
      // Clear the whole wheel, pass the brake request
      lag_mem[w]  = '0;
      perr_mem[w] = '0;
      spd_mem[w]  = '0;
      r.brake     = it.brake;
    end else begin
      // Reporting filter, round to nearest
      s = spd_mem[w];
      s = s + (((bd - s) * FILTER_ALPHA + 32768) >>> 16);
      s = clip24(s);
      spd_mem[w] = s[23:0];
      r.speed    = s[23:0];
      if (tgt == 0) begin
        // Coast: drop the loop state
        lag_mem[w]  = '0;
        perr_mem[w] = '0;
      end else begin
        abs_t = (tgt < 0) ? -tgt : tgt;
        lim   = longint'(loop_cfg.lag_base) * 256 + 4 * abs_t;
        lag   = longint'(lag_mem[w]) + tgt - bd;
        if (lag > lim) lag = lim;
        else if (lag < -lim) lag = -lim;
        lag_mem[w] = lag[23:0];
        e = clip24(tgt - bd);
        u = ff * tgt + kp * e + ki * lag + kd * (e - longint'(perr_mem[w]));
        perr_mem[w] = e[23:0];
        // Saturate, round to nearest with ties away from zero, apply polarity
        fs = longint'(loop_cfg.dfs) * 65536;
        if (u > fs) u = fs;
        if (u < -fs) u = -fs;
        mag = (((u < 0) ? -u : u) + 32768) >>> 16;
        mag = (u < 0) ? -mag : mag;
        if (loop_cfg.drv_inv[w]) mag = -mag;
        r.duty = mag[10:0];
      end
    end
    return r;
  endfunction

  function automatic wsp_pkg::item_t make_item(input int w, input int delta, input int tgt,
                                               input bit stop, input bit brake);
    wsp_pkg::item_t it;
    it.wheel     = 2'(w);
    it.raw_delta = 16'(delta);
    it.target    = 20'(tgt);
    it.stop      = stop;
    it.brake     = brake;
    return it;
  endfunction

  // Mostly tracking ticks (delta near target), some extremes and noise
  function automatic wsp_pkg::item_t rand_item();
    wsp_pkg::item_t it;
    int    pick;
    int    tv;
    int    dv;
    it.wheel = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    case (pick)
      0: tv = 0;
      1: tv = ($urandom_range(0, 1) != 0) ? 524287 : -524288;
      2, 3: tv = $signed(20'($urandom));
      default: tv = int'($urandom_range(0, 32768)) - 16384;
    endcase
    it.target = 20'(tv);
    pick = $urandom_range(0, 9);
    case (pick)
      0: dv = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      1, 2: dv = $signed(16'($urandom));
      default: dv = (tv >>> 8) + int'($urandom_range(0, 8)) - 4;
    endcase
    it.raw_delta = 16'(dv);
    it.stop  = ($urandom_range(0, 19) == 0);
    it.brake = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic loop_cfg_t rand_cfg(input bit wild);
    loop_cfg_t c;
    c.ff       = wild ? 16'($urandom) : 16'($urandom_range(0, 1023));
    c.kp       = wild ? 16'($urandom) : 16'($urandom_range(0, 1023));
    c.ki       = wild ? 16'($urandom) : 16'($urandom_range(0, 255));
    c.kd       = wild ? 16'($urandom) : 16'($urandom_range(0, 1023));
    c.dfs      = 10'($urandom_range(1, 1023));
    c.lag_base = 12'($urandom);
    c.drv_inv  = 4'($urandom);
    c.enc_inv  = 4'($urandom);
    return c;
  endfunction

  // Stop offering items and hold until every result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk_i);
  endtask

  // Send one item; tvalid stays high so a back-to-back item keeps it up
  task automatic send_item(input wsp_pkg::item_t it);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.target, it.raw_delta, it.wheel};
    s_axis_tuser  <= {it.brake, it.stop};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_duties.push_back(predict_drive(it));
    items_sent++;
  endtask

  task automatic put_reg(input logic [wsp_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Write all registers once the loop is idle
  task automatic program_regs(input loop_cfg_t c);
    wait_drained();
    put_reg(wsp_pkg::CFG_FF_GAIN, c.ff);
    put_reg(wsp_pkg::CFG_KP_GAIN, c.kp);
    put_reg(wsp_pkg::CFG_KI_GAIN, c.ki);
    put_reg(wsp_pkg::CFG_KD_GAIN, c.kd);
    put_reg(wsp_pkg::CFG_DUTY_FS, 16'(c.dfs));
    put_reg(wsp_pkg::CFG_LAG_BASE, 16'(c.lag_base));
    put_reg(wsp_pkg::CFG_DRV_INV, 16'(c.drv_inv));
    put_reg(wsp_pkg::CFG_ENC_INV, 16'(c.enc_inv));
    cfg_we_i <= 1'b0;
    loop_cfg = c;
    phases_run++;
  endtask

  // Registers at their reset values: zero gains, filter and delta only
  task automatic test_reset_values();
    send_item(make_item(0, 100, 2560, 1'b0, 1'b0));
    send_item(make_item(1, -7, -512, 1'b0, 1'b0));
    send_item(make_item(2, 32767, 0, 1'b0, 1'b1));
    send_item(make_item(3, -32768, 524287, 1'b0, 1'b0));
  endtask

  // Field extremes, stop and brake, lag clamp, zero full scale
  task automatic test_directed_corners();
    loop_cfg_t c;
    c = '{ff: 16'hFFFF, kp: 16'hFFFF, ki: 16'hFFFF, kd: 16'hFFFF, dfs: 10'd1023,
          lag_base: 12'hFFF, drv_inv: 4'b1010, enc_inv: 4'b0101};
    program_regs(c);
    send_item(make_item(0, -32768, 0, 1'b0, 1'b0));
    send_item(make_item(0, 32767, 524287, 1'b0, 1'b0));
    send_item(make_item(1, -32768, -524288, 1'b0, 1'b0));
    send_item(make_item(2, 0, 1, 1'b0, 1'b0));
    send_item(make_item(3, 32767, -1, 1'b0, 1'b0));
    send_item(make_item(2, -32768, -524288, 1'b0, 1'b0));
    send_item(make_item(1, 123, 4000, 1'b1, 1'b1));
    send_item(make_item(3, -5, 777, 1'b1, 1'b0));
    send_item(make_item(0, 0, 0, 1'b1, 1'b1));
    send_item(make_item(1, 0, 0, 1'b0, 1'b1));
    // Build lag on a stalled wheel until it clamps, then let it unwind
    c = '{ff: 16'd256, kp: 16'd512, ki: 16'd16, kd: 16'd128, dfs: 10'd400,
          lag_base: 12'd0, drv_inv: 4'b0000, enc_inv: 4'b0000};
    program_regs(c);
    repeat (5) send_item(make_item(3, 0, 2560, 1'b0, 1'b0));
    send_item(make_item(3, 40, 2560, 1'b0, 1'b0));
    // Zero full scale forces zero duty
    c.dfs = 10'd0;
    program_regs(c);
    send_item(make_item(3, 0, 2560, 1'b0, 1'b0));
    send_item(make_item(0, -300, -524288, 1'b0, 1'b0));
  endtask

  // Random ticks over several register settings and idle patterns
  task automatic test_random_settings();
    loop_cfg_t c;
    int        per_phase;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: c = '{ff: 16'hFFFF, kp: 16'hFFFF, ki: 16'hFFFF, kd: 16'hFFFF, dfs: 10'd1023,
                 lag_base: 12'hFFF, drv_inv: 4'hF, enc_inv: 4'hF};
        1: begin
          c          = rand_cfg(1'b0);
          c.dfs      = 10'd1;
          c.lag_base = 12'd0;
          c.drv_inv  = 4'h0;
          c.enc_inv  = 4'h0;
        end
        default: c = rand_cfg(p[0]);
      endcase
      program_regs(c);
      for (int i = 0; i < per_phase; i++) begin
        // Redraw idle pattern now and then, leaving idle-free stretches
        if (i % 40 == 0) begin
          src_idle_on  = ($urandom_range(0, 3) != 0);
          sink_idle_on = ($urandom_range(0, 3) != 0);
        end
        send_item(rand_item());
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Result side: random stalls after each taken item while sink idling is on
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sink_draw = sink_idle_on ? $urandom_range(0, 7) : 0;
      sink_stall    <= sink_draw;
      m_axis_tready <= (sink_draw == 0);
    end else if (sink_stall > 1) begin
      sink_stall <= sink_stall - 1;
    end else begin
      sink_stall    <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res.wheel = m_axis_tdata[1:0];
      got_res.duty  = m_axis_tdata[12:2];
      got_res.speed = m_axis_tdata[36:13];
      got_res.delta = m_axis_tdata[52:37];
      got_res.brake = m_axis_tuser[0];
      results_seen++;
      if (expected_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: wheel %0d duty %0d brake %0b speed %0d delta %0d",
                   got_res.wheel, got_res.duty, got_res.brake, got_res.speed,
                   got_res.delta);
      end else begin
        want_res = expected_duties.pop_front();
        if (got_res.wheel !== want_res.wheel || got_res.duty !== want_res.duty ||
            got_res.brake !== want_res.brake || got_res.speed !== want_res.speed ||
            got_res.delta !== want_res.delta) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch (exp/act): wheel %0d/%0d duty %0d/%0d brake %0b/%0b",
                      " speed %0d/%0d delta %0d/%0d"},
                     want_res.wheel, got_res.wheel, want_res.duty, got_res.duty,
                     want_res.brake, got_res.brake, want_res.speed, got_res.speed,
                     want_res.delta, got_res.delta);
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    loop_cfg = '{ff: 16'd0, kp: 16'd0, ki: 16'd0, kd: 16'd0, dfs: wsp_pkg::DUTY_FS_RST,
                 lag_base: wsp_pkg::LAG_BASE_RST, drv_inv: 4'h0, enc_inv: 4'h0};
    for (int w = 0; w < wsp_pkg::WHEELS; w++) begin
      lag_mem[w]  = '0;
      perr_mem[w] = '0;
      spd_mem[w]  = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_directed_corners();
    test_random_settings();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("tb: %0d ticks sent, %0d results checked over %0d register settings",
             items_sent, results_seen, phases_run + 1);
    $display("tb: %0d mismatches, %0d results still outstanding",
             mismatches, expected_duties.size());
    if (mismatches == 0 && expected_duties.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
